>>> hw/rtl/hec_pkg.sv
// Package with the types, constants and helper functions of the Hamming coder.
package hec_pkg;

	localparam int MAX_DATA_BITS = 57;
	localparam int DATA_W        = 57;
	localparam int CODE_W        = 63;
	localparam int SYN_W         = 6;
	localparam int LEN_W         = 6;
	localparam logic [LEN_W-1:0] DATA_LENGTH_RESET = LEN_W'(57);

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [CODE_W-1:0] word;
	} word_item_t;

	typedef struct packed {
		logic              mode;
		logic [CODE_W-1:0] word;
		logic [SYN_W-1:0]  checks;
	} chk_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] codeword;
		logic [SYN_W-1:0]  syndrome;
		logic              corrected;
		logic              syndrome_out_of_range;
	} res_item_t;

	function automatic logic [LEN_W-1:0] eff_k(input logic [LEN_W-1:0] dl);
		logic [LEN_W-1:0] k;
		k = dl;
		if (k == '0) k = LEN_W'(1);
		if (k > LEN_W'(MAX_DATA_BITS)) k = LEN_W'(MAX_DATA_BITS);
		return k;
	endfunction

	function automatic logic [LEN_W-1:0] code_len(input logic [LEN_W-1:0] k);
		logic [LEN_W-1:0] r;
		if (k <= LEN_W'(1))       r = LEN_W'(2);
		else if (k <= LEN_W'(4))  r = LEN_W'(3);
		else if (k <= LEN_W'(11)) r = LEN_W'(4);
		else if (k <= LEN_W'(26)) r = LEN_W'(5);
		else                      r = LEN_W'(6);
		return k + r;
	endfunction

	function automatic logic [63:0] low_mask(input logic [LEN_W-1:0] m);
		return (64'd1 << m) - 64'd1;
	endfunction

	function automatic logic is_pow2(input int v);
		return (v != 0) && ((v & (v - 1)) == 0);
	endfunction

	function automatic logic [CODE_W-1:0] scatter_data(input logic [DATA_W-1:0] d);
		logic [CODE_W-1:0] w;
		logic [LEN_W-1:0]  j;
		w = '0;
		j = '0;
		for (int pos = 1; pos <= CODE_W; pos++) begin
			if (!is_pow2(pos)) begin
				w[pos-1] = d[j];
				j = j + LEN_W'(1);
			end
		end
		return w;
	endfunction

	function automatic logic [CODE_W-1:0] check_mask(input int b);
		logic [CODE_W-1:0] m;
		m = '0;
		for (int pos = 1; pos <= CODE_W; pos++) begin
			m[pos-1] = ((pos >> b) & 1) != 0;
		end
		return m;
	endfunction

endpackage

>>> hw/rtl/hec_scatter.sv
// First pipeline stage: places data bits or masks the received word to the code length.
module hec_scatter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [5:0]          k,
	input  logic [5:0]          n,
	input  logic                up_valid,
	output logic                up_ready,
	input  hec_pkg::word_item_t up_item,
	output logic                dn_valid,
	input  logic                dn_ready,
	output hec_pkg::word_item_t dn_item
);
	import hec_pkg::*;

	logic       valid_s1;
	word_item_t item_s1;
	word_item_t next_item;
	logic [DATA_W-1:0] data_mask;
	logic [CODE_W-1:0] code_mask;

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_item  = item_s1;

	always_comb begin
		data_mask      = DATA_W'(low_mask(k));
		code_mask      = CODE_W'(low_mask(n));
		next_item.mode = up_item.mode;
		if (up_item.mode == MODE_ENCODE) begin
			next_item.word = scatter_data(up_item.word[DATA_W-1:0] & data_mask);
		end else begin
			next_item.word = up_item.word & code_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_s1 <= next_item;
		end
	end

endmodule

>>> hw/rtl/hec_check.sv
// Second pipeline stage: forms the parity checks over the positioned word.
module hec_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  hec_pkg::word_item_t up_item,
	output logic                dn_valid,
	input  logic                dn_ready,
	output hec_pkg::chk_item_t  dn_item
);
	import hec_pkg::*;

	logic             valid_s2;
	chk_item_t        item_s2;
	logic [SYN_W-1:0] checks;

	assign up_ready = !valid_s2 || dn_ready;
	assign dn_valid = valid_s2;
	assign dn_item  = item_s2;

	always_comb begin
		for (int b = 0; b < SYN_W; b++) begin
			checks[b] = ^(up_item.word & check_mask(b));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_s2.mode   <= up_item.mode;
			item_s2.word   <= up_item.word;
			item_s2.checks <= checks;
		end
	end

endmodule

>>> hw/rtl/hec_correct.sv
// Third pipeline stage: inserts parity bits or corrects the word, and holds the result.
module hec_correct (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [5:0]         n,
	input  logic               up_valid,
	output logic               up_ready,
	input  hec_pkg::chk_item_t up_item,
	output logic               dn_valid,
	input  logic               dn_ready,
	output hec_pkg::res_item_t dn_item
);
	import hec_pkg::*;

	logic              valid_s3;
	res_item_t         item_s3;
	res_item_t         next_item;
	logic [CODE_W-1:0] parity_bits;
	logic [CODE_W-1:0] flip;
	logic              in_range;

	assign up_ready = !valid_s3 || dn_ready;
	assign dn_valid = valid_s3;
	assign dn_item  = item_s3;

	always_comb begin
		parity_bits = '0;
		for (int b = 0; b < SYN_W; b++) begin
			parity_bits[(1 << b) - 1] = up_item.checks[b];
		end
		in_range = (up_item.checks != '0) && (up_item.checks <= n);
		flip     = CODE_W'(64'd1 << (up_item.checks - SYN_W'(1)));
		if (up_item.mode == MODE_ENCODE) begin
			next_item.codeword              = up_item.word | parity_bits;
			next_item.syndrome              = '0;
			next_item.corrected             = 1'b0;
			next_item.syndrome_out_of_range = 1'b0;
		end else begin
			next_item.codeword              = in_range ? (up_item.word ^ flip) : up_item.word;
			next_item.syndrome              = up_item.checks;
			next_item.corrected             = in_range;
			next_item.syndrome_out_of_range = (up_item.checks != '0) && !in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_s3 <= next_item;
		end
	end

endmodule

>>> hw/rtl/hamming_encoder_corrector.sv
// Top level of the configurable Hamming single-error-correcting coder.
// An accepted transaction passes the scatter, check and correct registers in turn.
// Throughput is one transaction per cycle while the output is taken; a register stage
// stalls only when it is full and the stage after it is not taking its item.
// Reset clears all stage valid bits and sets the data length to 57.
module hamming_encoder_corrector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,   // data_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // word[62:0], zero pad[63]
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // codeword[62:0], syndrome[68:63], zero pad[71:69]
	output logic [1:0]  m_axis_tuser   // corrected[0], syndrome_out_of_range[1]
);
	import hec_pkg::*;

	logic [LEN_W-1:0] data_length_q;
	logic [LEN_W-1:0] k;
	logic [LEN_W-1:0] n;

	word_item_t in_item;
	word_item_t item_a;
	chk_item_t  item_b;
	res_item_t  item_c;
	logic       valid_a;
	logic       ready_a;
	logic       valid_b;
	logic       ready_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_length_q <= DATA_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			data_length_q <= cfg_wr_data;
		end
	end

	assign k = eff_k(data_length_q);
	assign n = code_len(k);

	assign in_item.mode = s_axis_tuser;
	assign in_item.word = s_axis_tdata[CODE_W-1:0];

	hec_scatter u_scatter (
		.clk      (clk),
		.arst_n   (arst_n),
		.k        (k),
		.n        (n),
		.up_valid (s_axis_tvalid),
		.up_ready (s_axis_tready),
		.up_item  (in_item),
		.dn_valid (valid_a),
		.dn_ready (ready_a),
		.dn_item  (item_a)
	);

	hec_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_a),
		.up_ready (ready_a),
		.up_item  (item_a),
		.dn_valid (valid_b),
		.dn_ready (ready_b),
		.dn_item  (item_b)
	);

	hec_correct u_correct (
		.clk      (clk),
		.arst_n   (arst_n),
		.n        (n),
		.up_valid (valid_b),
		.up_ready (ready_b),
		.up_item  (item_b),
		.dn_valid (m_axis_tvalid),
		.dn_ready (m_axis_tready),
		.dn_item  (item_c)
	);

	assign m_axis_tdata = {3'b000, item_c.syndrome, item_c.codeword};
	assign m_axis_tuser = {item_c.syndrome_out_of_range, item_c.corrected};

endmodule
